// ===== rtl/core/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths, default sizes and controller/datapath bundles for the
// TLB page translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  // Fixed field widths
  localparam int unsigned AddrW  = 16;
  localparam int unsigned PageW  = 8;
  localparam int unsigned OffsW  = 8;
  localparam int unsigned FrameW = 8;

  // Default sizes
  localparam int unsigned TlbEntriesDef = 16;
  localparam int unsigned PageCountDef  = 256;
  localparam int unsigned FrameCountDef = 256;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture address, start page table read
    logic commit;  // resolve lookup, update state, load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } status_t;

endpackage

// ===== rtl/core/tlbpt_req_if.sv =====
// ----------------------------------------------------------------------------
// tlbpt_req_if
// Request channel: logical address with valid/ready.
// ----------------------------------------------------------------------------
interface tlbpt_req_if;
  logic                             valid;
  logic                             ready;
  logic [tlbpt_pkg::AddrW-1:0]      virt_addr;

  modport source (output valid, output virt_addr, input ready);
  modport sink   (input valid, input virt_addr, output ready);
endinterface

// ===== rtl/core/tlbpt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tlbpt_rsp_if
// Response channel: translated address, frame and lookup flags.
// ----------------------------------------------------------------------------
interface tlbpt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [tlbpt_pkg::AddrW-1:0]      physical_address;
  logic [tlbpt_pkg::FrameW-1:0]     frame_out;
  logic                             tlb_hit;
  logic                             pt_fault;

  modport source (output valid, output physical_address, output frame_out,
                  output tlb_hit, output pt_fault, input ready);
  modport sink   (input valid, input physical_address, input frame_out,
                  input tlb_hit, input pt_fault, output ready);
endinterface

// ===== rtl/core/tlb_page_translator_top.sv =====
// ----------------------------------------------------------------------------
// tlb_page_translator_top
// Logical to physical address translation through a recency-ordered TLB
// backed by a direct-indexed page table with on-demand frame allocation.
// ----------------------------------------------------------------------------
// Flow: a request is taken in the idle state, which captures the address and reads
//   the page table port; the lookup state then does the TLB compare and table
//   write-back and loads the result register, stalling while that register holds
//   an untaken result. A new request is taken only once the previous one is committed.
// A result waits in the output register; the next request is taken meanwhile.
// Reset clears the TLB fill count, the page-table valid bits and the free-frame
//   counter at once; no clearing pass is needed.
module tlb_page_translator_top #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TlbEntriesDef,
  parameter int unsigned PAGE_COUNT  = tlbpt_pkg::PageCountDef,
  parameter int unsigned FRAME_COUNT = tlbpt_pkg::FrameCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlbpt_req_if.sink   req_i,
  tlbpt_rsp_if.source rsp_o
);

  tlbpt_pkg::cmd_t    cmd;
  tlbpt_pkg::status_t status;

  tlbpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .virt_addr_i        (req_i.virt_addr),
    .out_ready_i        (rsp_o.ready),
    .out_valid_o        (rsp_o.valid),
    .physical_address_o (rsp_o.physical_address),
    .frame_out_o        (rsp_o.frame_out),
    .tlb_hit_o          (rsp_o.tlb_hit),
    .pt_fault_o         (rsp_o.pt_fault)
  );

endmodule

// ===== rtl/core/tlbpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Two-state controller: take a request, then resolve it once the result
// register has room.
// ----------------------------------------------------------------------------
module tlbpt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tlbpt_pkg::status_t status_i,
  output tlbpt_pkg::cmd_t    cmd_o
);

  localparam logic StIdle   = 1'b0;
  localparam logic StLookup = 1'b1;

  logic state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.commit  = 1'b0;
    in_ready_o    = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StLookup;
        end
      end
      StLookup: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/tlbpt_datapath.sv =====
// ----------------------------------------------------------------------------
// tlbpt_datapath
// Recency-ordered TLB, direct-indexed page table with valid bits, free-frame
// allocator and the result register.
// ----------------------------------------------------------------------------
module tlbpt_datapath #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TlbEntriesDef,
  parameter int unsigned PAGE_COUNT  = tlbpt_pkg::PageCountDef,
  parameter int unsigned FRAME_COUNT = tlbpt_pkg::FrameCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlbpt_pkg::cmd_t               cmd_i,
  output tlbpt_pkg::status_t            status_o,
  input  logic [tlbpt_pkg::AddrW-1:0]   virt_addr_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [tlbpt_pkg::AddrW-1:0]   physical_address_o,
  output logic [tlbpt_pkg::FrameW-1:0]  frame_out_o,
  output logic                          tlb_hit_o,
  output logic                          pt_fault_o
);

  localparam int unsigned PageW  = tlbpt_pkg::PageW;
  localparam int unsigned OffsW  = tlbpt_pkg::OffsW;
  localparam int unsigned FrameW = tlbpt_pkg::FrameW;
  localparam int unsigned FillW  = $clog2(TLB_ENTRIES + 1);
  localparam int unsigned PageAw = $clog2(PAGE_COUNT);
  localparam int unsigned NfW    = $clog2(FRAME_COUNT + 1);
  localparam int unsigned RemW   = PageW + 4;
  localparam int unsigned ModSteps = 4;  // quotient of an 8-bit page by >= 16 fits in 4 bits

  // ---------------------------------------------------------------- request
  logic [PageW-1:0]  page_q;
  logic [OffsW-1:0]  offset_q;
  logic [RemW-1:0]   page_rem;

  // Page number modulo PAGE_COUNT by restoring subtraction
  always_comb begin
    page_rem = RemW'(virt_addr_i[tlbpt_pkg::AddrW-1:OffsW]);
    for (int s = ModSteps - 1; s >= 0; s--) begin
      if (page_rem >= (RemW'(PAGE_COUNT) << s)) begin
        page_rem = page_rem - (RemW'(PAGE_COUNT) << s);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q   <= page_rem[PageW-1:0];
      offset_q <= virt_addr_i[OffsW-1:0];
    end
  end

  // ---------------------------------------------------------------- page table
  logic [FrameW-1:0]     table_mem [PAGE_COUNT];
  logic [FrameW-1:0]     table_rdata_q;
  logic [PAGE_COUNT-1:0] table_valid_q;
  logic [PageAw-1:0]     page_idx;
  logic                  fault;
  logic [FrameW-1:0]     frame_sel;

  assign page_idx = page_q[PageAw-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && fault) begin
      table_mem[page_idx] <= frame_sel;
    end
    if (cmd_i.load) begin
      table_rdata_q <= table_mem[page_rem[PageAw-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_valid_q <= '0;
    end else if (cmd_i.commit && fault) begin
      table_valid_q[page_idx] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- frame allocator
  logic [NfW-1:0] nf_q;
  logic [NfW-1:0] nf_wrap;

  // Wrap to frame 0 once all frames are handed out
  assign nf_wrap = (nf_q >= NfW'(FRAME_COUNT)) ? '0 : nf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q <= '0;
    end else if (cmd_i.commit && fault) begin
      nf_q <= nf_wrap + NfW'(1);
    end
  end

  // ---------------------------------------------------------------- TLB search
  logic [PageW-1:0]  tlb_page_q  [TLB_ENTRIES];
  logic [FrameW-1:0] tlb_frame_q [TLB_ENTRIES];
  logic [FillW-1:0]  fill_q;
  logic              hit;
  logic [FillW-1:0]  hit_pos;
  logic [FrameW-1:0] hit_frame;

  // First matching slot among the filled ones
  always_comb begin
    hit       = 1'b0;
    hit_pos   = '0;
    hit_frame = '0;
    for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
      if ((FillW'(k) < fill_q) && (tlb_page_q[k] == page_q)) begin
        hit       = 1'b1;
        hit_pos   = FillW'(k);
        hit_frame = tlb_frame_q[k];
      end
    end
  end

  // Frame resolution
  assign fault = !hit && !table_valid_q[page_idx];

  always_comb begin
    if (hit) begin
      frame_sel = hit_frame;
    end else if (!fault) begin
      frame_sel = table_rdata_q;
    end else begin
      frame_sel = FrameW'(nf_wrap);
    end
  end

  // ---------------------------------------------------------------- TLB update
  logic             full;
  logic             shift_en;
  logic [FillW-1:0] shift_from;
  logic [FillW-1:0] last_slot;

  assign full       = (fill_q == FillW'(TLB_ENTRIES));
  assign shift_en   = hit || full;
  assign shift_from = hit ? hit_pos : '0;
  assign last_slot  = shift_en ? (fill_q - FillW'(1)) : fill_q;

  for (genvar k = 0; k < TLB_ENTRIES; k++) begin : g_slot
    logic take_new;
    logic take_next;

    assign take_new  = (FillW'(k) == last_slot);
    assign take_next = shift_en && (FillW'(k) >= shift_from) && (FillW'(k) < last_slot);

    if (k < TLB_ENTRIES - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (cmd_i.commit) begin
          if (take_new) begin
            tlb_page_q[k]  <= page_q;
            tlb_frame_q[k] <= frame_sel;
          end else if (take_next) begin
            tlb_page_q[k]  <= tlb_page_q[k+1];
            tlb_frame_q[k] <= tlb_frame_q[k+1];
          end
        end
      end
    end else begin : g_top
      // Newest slot only ever takes a new entry
      always_ff @(posedge clk_i) begin
        if (cmd_i.commit && take_new && !take_next) begin
          tlb_page_q[k]  <= page_q;
          tlb_frame_q[k] <= frame_sel;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.commit && !shift_en) begin
      fill_q <= fill_q + FillW'(1);
    end
  end

  // ---------------------------------------------------------------- result register
  logic              out_valid_q;
  logic [FrameW-1:0] out_frame_q;
  logic [OffsW-1:0]  out_offset_q;
  logic              out_hit_q;
  logic              out_fault_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_frame_q  <= frame_sel;
      out_offset_q <= offset_q;
      out_hit_q    <= hit;
      out_fault_q  <= fault;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = {out_frame_q, out_offset_q};
  assign frame_out_o        = out_frame_q;
  assign tlb_hit_o          = out_hit_q;
  assign pt_fault_o         = out_fault_q;

endmodule
